### hw/rtl/palette_alpha_blend_blitter_assert.svh
// Assertion macros used by the blitter RTL.
`ifndef PALETTE_ALPHA_BLEND_BLITTER_ASSERT_SVH
`define PALETTE_ALPHA_BLEND_BLITTER_ASSERT_SVH

// A condition that must hold in the same cycle as its trigger.
`define PABB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blitter check failed: same-cycle implication");

// A condition that must hold in the cycle after its trigger.
`define PABB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blitter check failed: next-cycle implication");

`endif

### hw/rtl/pabb_pkg.sv
// Shared constants, types and pixel helper functions for the blitter.
package pabb_pkg;

   // Default screen geometry.
   localparam int unsigned DEFAULT_SCREEN_COLUMNS = 240;
   localparam int unsigned DEFAULT_SCREEN_ROWS    = 320;

   localparam int unsigned PALETTE_DEPTH = 256;
   localparam int unsigned CSR_ADDR_W    = 3;

   // Command codes carried in the request tuser field.
   localparam logic [2:0] CMD_LOAD   = 3'd0;
   localparam logic [2:0] CMD_BLEND  = 3'd1;
   localparam logic [2:0] CMD_GLYPH  = 3'd2;
   localparam logic [2:0] CMD_DIRECT = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   // Source depth codes.
   localparam logic [1:0] DEPTH_1BPP = 2'd0;
   localparam logic [1:0] DEPTH_2BPP = 2'd1;
   localparam logic [1:0] DEPTH_4BPP = 2'd2;
   localparam logic [1:0] DEPTH_8BPP = 2'd3;

   // Register index of depth_code (bit 2 of the byte address).
   localparam logic CSR_DEPTH_INDEX = 1'b0;

   // Green in the upper half, red and blue in the lower half.
   localparam logic [31:0] SPLIT_MASK = 32'h07E0_F81F;

   // Operands handed to the blend unit.
   typedef struct packed {
      logic [15:0] fore;
      logic [15:0] back;
      logic [7:0]  alpha;
   } mix_operands_type;

   // Exchange the two bytes of a pixel.
   function automatic logic [15:0] swap16(input logic [15:0] c);
      return {c[7:0], c[15:8]};
   endfunction

   // Spread an RGB565 pixel into the split form.
   function automatic logic [31:0] split565(input logic [15:0] c);
      return {c, c} & SPLIT_MASK;
   endfunction

   // Convert a BGRA palette word into RGB565 with alpha above it.
   function automatic logic [23:0] pack_palette(input logic [31:0] pw);
      return {pw[31:24], pw[23:19], pw[15:10], pw[7:3]};
   endfunction

   // Select the palette index from the packed source byte, first pixel in the MSBs.
   function automatic logic [7:0] pick_index(input logic [1:0] depth,
                                             input logic [7:0] sbyte,
                                             input logic [2:0] sub);
      logic [2:0] shift;
      logic [7:0] shifted;
      logic [7:0] idx;
      shift   = 3'd6 - {sub[1:0], 1'b0};
      shifted = sbyte >> shift;
      unique case (depth)
         DEPTH_1BPP: idx = {7'b0, sbyte[3'd7 - sub]};
         DEPTH_2BPP: idx = {6'b0, shifted[1:0]};
         DEPTH_4BPP: idx = sub[0] ? {4'b0, sbyte[3:0]} : {4'b0, sbyte[7:4]};
         default:    idx = sbyte;
      endcase
      return idx;
   endfunction

endpackage

### hw/rtl/pabb_mix.sv
// Alpha blend unit: registered split-form product, then rescale and fold.
module pabb_mix
   import pabb_pkg::*;
(
   input  logic             clock,
   input  logic             load,
   input  mix_operands_type operands,
   output logic [15:0]      mixed
);

   logic [8:0]  alpha_sum;
   logic [5:0]  weight;
   logic [31:0] fore_split;
   logic [31:0] back_split;
   logic [31:0] prod_in;
   logic [31:0] prod_ff;
   logic [31:0] back_ff;
   logic [31:0] sum;
   logic [31:0] folded;

   // Round the 8-bit alpha down to a weight of 0 to 32.
   assign alpha_sum = {1'b0, operands.alpha} + 9'd4;
   assign weight    = alpha_sum[8:3];

   // Difference times weight, wrapping at 32 bits.
   assign fore_split = split565(operands.fore);
   assign back_split = split565(operands.back);
   assign prod_in    = (fore_split - back_split) * {26'b0, weight};

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         back_ff <= back_split;
      end
   end

   // Scale back, add the background and fold the halves together.
   assign sum    = {5'b0, prod_ff[31:5]} + back_ff;
   assign folded = sum & SPLIT_MASK;
   assign mixed  = folded[31:16] | folded[15:0];

endmodule

### hw/rtl/palette_alpha_blend_blitter.sv
// A command is accepted in the idle state, then passes the address, memory read, multiply
// and write-back steps of the single read-modify-write sequencer before its result is
// registered; a new command is taken only once the last one has left the write-back step.
// Reset clears the sequencer, the result valid flag and depth_code; the frame
// and palette memories are not cleared and hold nothing defined until written.
module palette_alpha_blend_blitter
   import pabb_pkg::*;
#(
   parameter int unsigned SCREEN_COLUMNS = DEFAULT_SCREEN_COLUMNS,
   parameter int unsigned SCREEN_ROWS    = DEFAULT_SCREEN_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata from bit 0: dest_x[11:0], dest_y[23:12], source_byte[31:24],
   // sub_position[34:32], pixel_color[50:35], palette_word[82:51], zero pad.
   input  logic [87:0]           req_tdata,
   // tuser from bit 0: command[2:0].
   input  logic [2:0]            req_tuser,
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata from bit 0: read_value[15:0].
   output logic [15:0]           rsp_tdata,
   // tuser from bit 0: did_write[0].
   output logic [0:0]            rsp_tuser,
   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   `include "palette_alpha_blend_blitter_assert.svh"

   localparam int unsigned CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADDR,
      S_READ,
      S_MIX,
      S_WRITE
   } state_type;

   state_type        state_ff;
   logic [1:0]       depth_ff;

   // Captured request fields.
   logic [2:0]       cmd_ff;
   logic [11:0]      x_ff;
   logic [11:0]      y_ff;
   logic [7:0]       sbyte_ff;
   logic [2:0]       sub_ff;
   logic [15:0]      color_ff;
   logic [31:0]      pw_ff;

   // Address step results.
   logic             on_in;
   logic             on_ff;
   logic [21:0]      linear;
   logic [ADDR_W-1:0] addr_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]       index_in;
   logic [7:0]       index_ff;

   // Memories and their registered read data.
   logic [15:0]      frame_mem [CELLS];
   logic [23:0]      pal_mem [PALETTE_DEPTH];
   logic [15:0]      frame_rd_ff;
   logic [23:0]      pal_rd_ff;

   // Write-back and result.
   mix_operands_type operands;
   logic [15:0]      mixed;
   logic             advance;
   logic             glyph_bit;
   logic             frame_we;
   logic [15:0]      frame_wdata;
   logic             pal_we;
   logic [15:0]      value_in;
   logic             wrote_in;
   logic             rsp_valid_ff;
   logic [15:0]      rsp_value_ff;
   logic             rsp_wrote_ff;

   // Register port: writes complete in the access phase, reads return the value.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_DEPTH_INDEX) ? {30'b0, depth_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_1BPP;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == CSR_DEPTH_INDEX)) begin
         depth_ff <= csr_pwdata[1:0];
      end
   end

   // Bounds check, linear address and palette index from the captured transaction.
   assign on_in = !x_ff[11] && !y_ff[11] &&
                  (x_ff[10:0] < 11'(SCREEN_COLUMNS)) &&
                  (y_ff[10:0] < 11'(SCREEN_ROWS));
   assign linear   = {11'b0, y_ff[10:0]} * 22'(SCREEN_COLUMNS) + {11'b0, x_ff[10:0]};
   assign addr_in  = linear[ADDR_W-1:0];
   assign index_in = pick_index(depth_ff, sbyte_ff, sub_ff);

   // Blend operands from the memory read data.
   assign operands.fore  = pal_rd_ff[15:0];
   assign operands.back  = swap16(frame_rd_ff);
   assign operands.alpha = pal_rd_ff[23:16];

   pabb_mix u_mix (
      .clock    (clock),
      .load     (state_ff == S_MIX),
      .operands (operands),
      .mixed    (mixed)
   );

   // The last step waits while an earlier result still sits in the output register.
   assign advance   = (state_ff == S_WRITE) && (!rsp_valid_ff || rsp_tready);
   assign glyph_bit = sbyte_ff[3'd7 - sub_ff];

   // Write-back decisions and result value per command.
   always_comb begin
      frame_we    = 1'b0;
      frame_wdata = swap16(color_ff);
      pal_we      = 1'b0;
      value_in    = 16'h0000;
      wrote_in    = 1'b0;
      unique case (cmd_ff)
         CMD_LOAD: begin
            pal_we   = advance;
            wrote_in = 1'b1;
         end
         CMD_BLEND: begin
            frame_we    = advance && on_ff;
            frame_wdata = swap16(mixed);
            wrote_in    = on_ff;
         end
         CMD_GLYPH: begin
            frame_we = advance && on_ff && glyph_bit;
            wrote_in = on_ff && glyph_bit;
         end
         CMD_DIRECT: begin
            frame_we = advance && on_ff;
            wrote_in = on_ff;
         end
         CMD_READ: begin
            value_in = on_ff ? swap16(frame_rd_ff) : 16'h0000;
         end
         default: begin
            wrote_in = 1'b0;
         end
      endcase
   end

   // Frame and palette memories, with registered reads.
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         frame_rd_ff <= frame_mem[addr_ff];
         pal_rd_ff   <= pal_mem[index_ff];
      end
      if (frame_we) begin
         frame_mem[addr_ff] <= frame_wdata;
      end
      if (pal_we) begin
         pal_mem[sbyte_ff] <= pack_palette(pw_ff);
      end
   end

   // Sequencer with the captured transaction and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result replaces the one taken in the same cycle.
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_ADDR;
               end
            end
            S_ADDR: begin
               state_ff <= S_READ;
            end
            S_READ: begin
               state_ff <= S_MIX;
            end
            S_MIX: begin
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (advance) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      // Payload registers.
      if (req_tvalid && req_tready) begin
         cmd_ff   <= req_tuser;
         x_ff     <= req_tdata[11:0];
         y_ff     <= req_tdata[23:12];
         sbyte_ff <= req_tdata[31:24];
         sub_ff   <= req_tdata[34:32];
         color_ff <= req_tdata[50:35];
         pw_ff    <= req_tdata[82:51];
      end
      if (state_ff == S_ADDR) begin
         on_ff    <= on_in;
         addr_ff  <= addr_in;
         index_ff <= index_in;
      end
      if (advance) begin
         rsp_value_ff <= value_in;
         rsp_wrote_ff <= wrote_in;
      end
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_wrote_ff;

   // Checks on the sequencer and the write-back.
   `PABB_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == S_ADDR)
   `PABB_ASSERT_IMPLIES(a_frame_we_bounds, clock, reset, frame_we, (state_ff == S_WRITE) && on_ff)
   `PABB_ASSERT_IMPLIES(a_result_from_write, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_WRITE))
   `PABB_ASSERT_IMPLIES(a_read_no_write, clock, reset, (state_ff == S_WRITE) && (cmd_ff == CMD_READ), !frame_we && !pal_we)

endmodule

### dv/pabb_checker.sv
// Result checker for the blitter: mirrors the depth register, predicts each result and compares.
module pabb_checker
   import pabb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel, watched only.
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // tdata from bit 0: dest_x, dest_y, source_byte, sub_position, pixel_color,
   // palette_word, zero pad.
   input  logic [87:0]           req_tdata,
   // tuser from bit 0: command.
   input  logic [2:0]            req_tuser,
   // Result channel, watched only.
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata from bit 0: read_value.
   input  logic [15:0]           rsp_tdata,
   // tuser from bit 0: did_write.
   input  logic [0:0]            rsp_tuser,
   // Register port, watched only.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic [31:0]           csr_prdata,
   input  logic                  csr_pready,
   // Results still owed by the block, and the number of failures so far.
   output int                    pending,
   output int                    failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS = DEFAULT_SCREEN_COLUMNS;
   localparam int ROWS = DEFAULT_SCREEN_ROWS;
   localparam logic [CSR_ADDR_W-1:0] DEPTH_ADDR = {CSR_DEPTH_INDEX, 2'b00};

   typedef struct packed {
      logic [15:0] read_value;
      logic        did_write;
   } pixel_outcome_type;

   // Shadow copies of the frame and palette. Pixels are kept unswapped here:
   // the byte swap on the way in is undone on the way out, so it never shows.
   logic [15:0]       shadow_frame [COLS*ROWS];
   logic [23:0]       shadow_palette [PALETTE_DEPTH];
   logic [1:0]        shadow_depth = DEPTH_1BPP;
   pixel_outcome_type outcome_q [$];
   int                fail_count = 0;

   initial begin
      pending  = 0;
      failures = 0;
   end

   // Linear frame address of a signed position, or -1 when off screen.
   function automatic int frame_index(input logic [11:0] x, input logic [11:0] y);
      int sx;
      int sy;
      sx = int'($signed(x));
      sy = int'($signed(y));
      if (sx < 0 || sx >= COLS || sy < 0 || sy >= ROWS) return -1;
      return sy * COLS + sx;
   endfunction

   // Palette slot taken from the packed source byte; the first pixel sits in the MSBs.
   function automatic logic [7:0] palette_slot(input logic [1:0] bpp_code,
                                               input logic [7:0] sbyte,
                                               input logic [2:0] sub);
      logic [7:0] shifted;
      case (bpp_code)
         DEPTH_1BPP: begin
            shifted = sbyte >> (7 - sub);
            return shifted & 8'h01;
         end
         DEPTH_2BPP: begin
            shifted = sbyte >> (6 - 2 * sub[1:0]);
            return shifted & 8'h03;
         end
         DEPTH_4BPP: return sub[0] ? {4'b0, sbyte[3:0]} : {4'b0, sbyte[7:4]};
         default:    return sbyte;
      endcase
   endfunction

   // Alpha mix of two RGB565 pixels with green split off into the upper half,
   // all in wrapping 32-bit arithmetic.
   function automatic logic [15:0] blend565(input logic [15:0] fore,
                                            input logic [15:0] back,
                                            input logic [7:0]  alpha);
      logic [31:0] weight;
      logic [31:0] fore_split;
      logic [31:0] back_split;
      logic [31:0] scaled;
      logic [31:0] mixed;
      weight     = (32'(alpha) + 32'd4) >> 3;
      fore_split = {fore, fore} & SPLIT_MASK;
      back_split = {back, back} & SPLIT_MASK;
      scaled     = (fore_split - back_split) * weight;
      mixed      = ((scaled >> 5) + back_split) & SPLIT_MASK;
      return mixed[31:16] | mixed[15:0];
   endfunction

   // Carry out one command on the shadow state and return the result it owes.
   function automatic pixel_outcome_type apply_command(input logic [2:0]  cmd,
                                                       input logic [87:0] fields);
      logic [11:0]       x;
      logic [11:0]       y;
      logic [7:0]        sbyte;
      logic [2:0]        sub;
      logic [15:0]       colour;
      logic [31:0]       pw;
      logic [23:0]       entry;
      int                at;
      pixel_outcome_type res;
      x      = fields[11:0];
      y      = fields[23:12];
      sbyte  = fields[31:24];
      sub    = fields[34:32];
      colour = fields[50:35];
      pw     = fields[82:51];
      res    = '0;
      at     = frame_index(x, y);
      case (cmd)
         CMD_LOAD: begin
            // B,G,R,A bytes reduced to RGB565 with the alpha byte above it.
            shadow_palette[sbyte] = {pw[31:24], pw[23:19], pw[15:10], pw[7:3]};
            res.did_write = 1'b1;
         end
         CMD_BLEND: if (at >= 0) begin
            entry = shadow_palette[palette_slot(shadow_depth, sbyte, sub)];
            shadow_frame[at] = blend565(entry[15:0], shadow_frame[at], entry[23:16]);
            res.did_write = 1'b1;
         end
         CMD_GLYPH: if (sbyte[7 - sub] && at >= 0) begin
            shadow_frame[at] = colour;
            res.did_write = 1'b1;
         end
         CMD_DIRECT: if (at >= 0) begin
            shadow_frame[at] = colour;
            res.did_write = 1'b1;
         end
         CMD_READ: if (at >= 0) begin
            res.read_value = shadow_frame[at];
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_outcome_type seen;
      pixel_outcome_type want;
      if (reset) begin
         shadow_depth = DEPTH_1BPP;
         outcome_q.delete();
      end else begin
         // Register transactions: follow writes, check reads.
         if (csr_psel && csr_penable && csr_pready && csr_paddr == DEPTH_ADDR) begin
            if (csr_pwrite) begin
               shadow_depth = csr_pwdata[1:0];
            end else if (csr_prdata !== {30'b0, shadow_depth}) begin
               $error("depth_code: expected %0h, actual %0h", {30'b0, shadow_depth},
                      csr_prdata);
               fail_count++;
            end
         end
         // Result transactions are matched against the oldest prediction first.
         if (rsp_tvalid && rsp_tready) begin
            seen.read_value = rsp_tdata;
            seen.did_write  = rsp_tuser[0];
            if (outcome_q.size() == 0) begin
               $error("unexpected result: read_value %h, did_write %b", seen.read_value,
                      seen.did_write);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (seen.read_value !== want.read_value) begin
                  $error("read_value: expected %h, actual %h", want.read_value,
                         seen.read_value);
                  fail_count++;
               end
               if (seen.did_write !== want.did_write) begin
                  $error("did_write: expected %b, actual %b", want.did_write,
                         seen.did_write);
                  fail_count++;
               end
            end
         end
         // Request transactions update the shadow state in arrival order.
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(apply_command(req_tuser, req_tdata));
         end
      end
      pending  <= outcome_q.size();
      failures <= fail_count;
   end

endmodule

### dv/tb_top.sv
// Testbench top for the blitter: clock, reset, stimulus, back-pressure and the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pabb_pkg::*;

   localparam int COLS            = DEFAULT_SCREEN_COLUMNS;
   localparam int ROWS            = DEFAULT_SCREEN_ROWS;
   localparam int RUN_LIMIT       = 400000;
   localparam int ITEMS_PER_PHASE = 280;
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] DEPTH_ADDR = {CSR_DEPTH_INDEX, 2'b00};

   typedef struct packed {
      logic [2:0]  cmd;
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  sbyte;
      logic [2:0]  sub;
      logic [15:0] colour;
      logic [31:0] pw;
   } blit_cmd_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_ONE_IN_FOUR,
      READY_SPARSE
   } ready_pattern_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // tdata from bit 0: dest_x, dest_y, source_byte, sub_position, pixel_color,
   // palette_word, zero pad.
   logic [87:0]           req_tdata   = '0;
   // tuser from bit 0: command.
   logic [2:0]            req_tuser   = CMD_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b1;
   // tdata from bit 0: read_value.
   logic [15:0]           rsp_tdata;
   // tuser from bit 0: did_write.
   logic [0:0]            rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int pending_results;
   int fail_total;

   // Which pixels and palette slots hold defined data; nothing undefined is ever read.
   bit                pixel_set [COLS*ROWS];
   bit                slot_set [PALETTE_DEPTH];
   logic [1:0]        depth_now = DEPTH_1BPP;
   int                burst_left = 0;
   int                cycle_count = 0;
   ready_pattern_type ready_pattern = READY_ALWAYS;
   int                pattern_left = 0;
   logic [1:0]        depth_plan [5] = '{DEPTH_8BPP, DEPTH_2BPP, DEPTH_4BPP, DEPTH_1BPP,
                                         DEPTH_8BPP};

   palette_alpha_blend_blitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pabb_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pending     (pending_results),
      .failures    (fail_total)
   );

   always #6 clock = ~clock;

   // Run limit, well above the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Result back-pressure: a random pattern, chosen anew when the current one runs out.
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         ready_pattern <= ready_pattern_type'($urandom_range(0, 3));
         pattern_left  <= $urandom_range(50, 300);
      end else begin
         pattern_left <= pattern_left - 1;
      end
      case (ready_pattern)
         READY_ALWAYS:      rsp_tready <= 1'b1;
         READY_COIN:        rsp_tready <= 1'($urandom_range(0, 1));
         READY_ONE_IN_FOUR: rsp_tready <= (pattern_left % 4 == 0);
         default:           rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // Linear frame address of a signed position, or -1 when off screen.
   function automatic int screen_addr(input logic [11:0] x, input logic [11:0] y);
      int sx;
      int sy;
      sx = int'($signed(x));
      sy = int'($signed(y));
      if (sx < 0 || sx >= COLS || sy < 0 || sy >= ROWS) return -1;
      return sy * COLS + sx;
   endfunction

   function automatic blit_cmd_type mk(input logic [2:0] cmd, input logic [11:0] x,
                                       input logic [11:0] y, input logic [7:0] sbyte,
                                       input logic [2:0] sub, input logic [15:0] colour,
                                       input logic [31:0] pw);
      blit_cmd_type c;
      c = '{cmd, x, y, sbyte, sub, colour, pw};
      return c;
   endfunction

   // Mostly the edge rows and columns so pixels are revisited, sometimes just
   // outside the screen, sometimes anywhere in the 12-bit range.
   function automatic logic [11:0] rand_coord(input int span);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 38) return 12'($urandom_range(0, 3));
      if (pick < 72) return 12'(span - 1 - int'($urandom_range(0, 3)));
      if (pick < 80) return 12'(span + int'($urandom_range(0, 3)));
      if (pick < 86) return 12'(-1 - int'($urandom_range(0, 3)));
      return 12'($urandom);
   endfunction

   // Put a palette slot into the bits of the source byte that the depth selects.
   function automatic logic [7:0] place_slot(input logic [1:0] bpp_code,
                                             input logic [7:0] sbyte,
                                             input logic [2:0] sub,
                                             input logic [7:0] slot);
      logic [7:0] b;
      b = sbyte;
      case (bpp_code)
         DEPTH_1BPP: b[7 - sub] = slot[0];
         DEPTH_2BPP: b[6 - 2 * sub[1:0] +: 2] = slot[1:0];
         DEPTH_4BPP: if (sub[0]) begin
            b[3:0] = slot[3:0];
         end else begin
            b[7:4] = slot[3:0];
         end
         default:    b = slot;
      endcase
      return b;
   endfunction

   // One random command that never reads an undefined pixel or palette slot.
   function automatic blit_cmd_type rand_command(input logic [1:0] bpp_code);
      blit_cmd_type c;
      int           pick;
      int           at;
      int           slot_count;
      int           slot;
      c.x      = rand_coord(COLS);
      c.y      = rand_coord(ROWS);
      c.sbyte  = 8'($urandom);
      c.sub    = 3'($urandom);
      c.colour = 16'($urandom);
      c.pw     = $urandom;
      pick     = $urandom_range(0, 99);
      if (pick < 10)      c.cmd = CMD_LOAD;
      else if (pick < 45) c.cmd = CMD_BLEND;
      else if (pick < 60) c.cmd = CMD_GLYPH;
      else if (pick < 75) c.cmd = CMD_DIRECT;
      else if (pick < 96) c.cmd = CMD_READ;
      else                c.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      at = screen_addr(c.x, c.y);
      // A pixel never written is painted first instead of being read or blended.
      if ((c.cmd == CMD_READ || c.cmd == CMD_BLEND) && at >= 0 && !pixel_set[at]) begin
         c.cmd = CMD_DIRECT;
      end
      // An on-screen blend must land on a loaded slot that this depth can reach.
      if (c.cmd == CMD_BLEND && at >= 0) begin
         slot_count = 1 << (1 << bpp_code);
         slot = $urandom_range(0, slot_count - 1);
         if (!slot_set[slot] && $urandom_range(0, 1) == 1) begin
            c.cmd   = CMD_LOAD;
            c.sbyte = 8'(slot);
         end else begin
            while (!slot_set[slot]) slot = (slot + 1) % slot_count;
            c.sbyte = place_slot(bpp_code, c.sbyte, c.sub, 8'(slot));
         end
      end
      return c;
   endfunction

   // Send one command, record what it defines, and pace the sender in bursts.
   task automatic issue(input blit_cmd_type c);
      int at;
      at = screen_addr(c.x, c.y);
      case (c.cmd)
         CMD_LOAD:              slot_set[c.sbyte] = 1'b1;
         CMD_BLEND, CMD_DIRECT: if (at >= 0) pixel_set[at] = 1'b1;
         CMD_GLYPH:             if (at >= 0 && c.sbyte[7 - c.sub]) pixel_set[at] = 1'b1;
         default: ;
      endcase
      req_tvalid <= 1'b1;
      req_tuser  <= c.cmd;
      req_tdata  <= {5'b0, c.pw, c.colour, c.sub, c.sbyte, c.y, c.x};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // Hold the sender off until every owed result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // One register transaction: setup cycle, then access until pready. The select
   // is left high so that a second transaction can follow at once.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The depth register must come out of reset at one bit per pixel.
      csr_access(1'b0, DEPTH_ADDR, '0);
      csr_release();

      // Directed part at one bit per pixel: palette extremes, screen edges,
      // drops outside the screen, glyph bits clear and set, blends, an unused code.
      issue(mk(CMD_LOAD,   12'd0,   12'd0,   8'h00, 3'd0, 16'h0000, 32'h0000_0000));
      issue(mk(CMD_LOAD,   12'h7FF, 12'h800, 8'h01, 3'd7, 16'hFFFF, 32'hFFFF_FFFF));
      issue(mk(CMD_LOAD,   12'h800, 12'h7FF, 8'hFF, 3'd3, 16'h5A5A, 32'h80F8_FC08));
      issue(mk(CMD_DIRECT, 12'd0,   12'd0,   8'h00, 3'd0, 16'hFFFF, 32'h0000_0000));
      issue(mk(CMD_DIRECT, 12'd239, 12'd319, 8'hFF, 3'd7, 16'h0000, 32'hFFFF_FFFF));
      issue(mk(CMD_DIRECT, 12'hFFF, 12'd0,   8'h00, 3'd0, 16'h1234, 32'h0000_0000));
      issue(mk(CMD_DIRECT, 12'd240, 12'd5,   8'h00, 3'd0, 16'h1234, 32'h0000_0000));
      issue(mk(CMD_DIRECT, 12'd5,   12'd320, 8'h00, 3'd0, 16'h1234, 32'h0000_0000));
      issue(mk(CMD_DIRECT, 12'h800, 12'h7FF, 8'h00, 3'd0, 16'hFFFF, 32'h0000_0000));
      issue(mk(CMD_READ,   12'd0,   12'd0,   8'h00, 3'd0, 16'h0000, 32'h0000_0000));
      issue(mk(CMD_READ,   12'd239, 12'd319, 8'h00, 3'd0, 16'hFFFF, 32'hFFFF_FFFF));
      issue(mk(CMD_READ,   12'h7FF, 12'h800, 8'hFF, 3'd7, 16'hFFFF, 32'hFFFF_FFFF));
      issue(mk(CMD_GLYPH,  12'd1,   12'd0,   8'h7F, 3'd0, 16'h1234, 32'h0000_0000));
      issue(mk(CMD_GLYPH,  12'd1,   12'd0,   8'h80, 3'd0, 16'hA5C3, 32'h0000_0000));
      issue(mk(CMD_GLYPH,  12'd2,   12'd0,   8'h01, 3'd7, 16'hFFFF, 32'h0000_0000));
      issue(mk(CMD_GLYPH,  12'hFFF, 12'd0,   8'hFF, 3'd3, 16'hFFFF, 32'h0000_0000));
      issue(mk(CMD_BLEND,  12'd0,   12'd0,   8'h80, 3'd0, 16'h0000, 32'h0000_0000));
      issue(mk(CMD_BLEND,  12'd239, 12'd319, 8'h00, 3'd5, 16'h0000, 32'h0000_0000));
      issue(mk(CMD_BLEND,  12'hFFB, 12'd3,   8'hAA, 3'd2, 16'h0000, 32'h0000_0000));
      issue(mk(CMD_BLEND,  12'd1,   12'd0,   8'hFE, 3'd7, 16'h0000, 32'h0000_0000));
      issue(mk(CMD_READ,   12'd0,   12'd0,   8'h00, 3'd0, 16'h0000, 32'h0000_0000));
      issue(mk(CMD_READ,   12'd1,   12'd0,   8'h00, 3'd0, 16'h0000, 32'h0000_0000));
      issue(mk(CMD_SPARE_LAST, 12'd0, 12'd0, 8'hFF, 3'd7, 16'hFFFF, 32'hFFFF_FFFF));
      issue(mk(CMD_READ,   12'd2,   12'd0,   8'h00, 3'd0, 16'h0000, 32'h0000_0000));

      // Random phases, one per entry of the depth plan, each opened with the block idle.
      foreach (depth_plan[p]) begin
         int pause_at;
         drain();
         csr_access(1'b1, DEPTH_ADDR, {30'b0, depth_plan[p]});
         csr_access(1'b0, DEPTH_ADDR, '0);
         csr_release();
         depth_now = depth_plan[p];
         pause_at  = $urandom_range(40, ITEMS_PER_PHASE - 40);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == pause_at) drain();
            issue(rand_command(depth_now));
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_total == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
